FILE: design/sks_pkg.sv
package sks_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;

    localparam int KEY_W      = 32;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int MODE_W     = 2;
    localparam int SPAN_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    // entry_count never exceeds 2047, so signed 12-bit positions cover lo, hi and mid
    localparam int POS_W      = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_SPAN = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BINARY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HYBRID = 2'd2;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    localparam logic [SPAN_W-1:0] DEF_LINEAR_SPAN = 10'd15;

    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        entry_index;
        logic signed [KEY_W-1:0] key_value;
    } sks_in_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic [CNT_W-1:0] compare_count;
    } sks_out_t;

    typedef struct packed {
        logic load_we;    // write table entry from the input request
        logic start;      // latch key, open span [0, n-1], clear count
        logic probe_mid;  // count a compare, read the middle of the span
        logic probe_lo;   // count a compare, read the low end of the span
        logic step_bin;   // narrow the span on the last probe
        logic step_lin;   // advance the low end by one
        logic publish;    // load the output register
        logic found;      // hit flag that goes with publish
    } sks_cmd_t;

    typedef struct packed {
        logic span_empty;
        logic span_small;
        logic key_eq;
        logic out_busy;
    } sks_stat_t;

endpackage

FILE: design/sks_ctrl.sv
module sks_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_kind,
    input  logic [sks_pkg::MODE_W-1:0]  search_mode,
    input  sks_pkg::sks_stat_t          stat,
    output sks_pkg::sks_cmd_t           cmd,
    output logic                        in_stall
);
    import sks_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_BIN_CHECK = 6'b000010,
        S_BIN_CMP   = 6'b000100,
        S_LIN_CHECK = 6'b001000,
        S_LIN_CMP   = 6'b010000,
        S_FINISH    = 6'b100000
    } sks_state_t;

    sks_state_t state_reg, state_next;
    logic       hybrid_reg, hybrid_next;
    logic       found_reg, found_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        hybrid_next = hybrid_reg;
        found_next  = found_reg;
        cmd         = '0;
        cmd.found   = found_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind == KIND_SEARCH)
                    begin
                        cmd.start   = 1'b1;
                        // the unused mode code runs as the hybrid
                        hybrid_next = (search_mode != MODE_BINARY);
                        state_next  = (search_mode == MODE_LINEAR) ? S_LIN_CHECK
                                                                   : S_BIN_CHECK;
                    end
                    else
                    begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            S_BIN_CHECK:
            begin
                if (stat.span_empty)
                begin
                    found_next = 1'b0;
                    state_next = S_FINISH;
                end
                else if (hybrid_reg && stat.span_small)
                begin
                    state_next = S_LIN_CHECK;
                end
                else
                begin
                    cmd.probe_mid = 1'b1;
                    state_next    = S_BIN_CMP;
                end
            end
            S_BIN_CMP:
            begin
                if (stat.key_eq)
                begin
                    found_next = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step_bin = 1'b1;
                    state_next   = S_BIN_CHECK;
                end
            end
            S_LIN_CHECK:
            begin
                if (stat.span_empty)
                begin
                    found_next = 1'b0;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.probe_lo = 1'b1;
                    state_next   = S_LIN_CMP;
                end
            end
            S_LIN_CMP:
            begin
                if (stat.key_eq)
                begin
                    found_next = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step_lin = 1'b1;
                    state_next   = S_LIN_CHECK;
                end
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            hybrid_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hybrid_reg <= hybrid_next;
            found_reg  <= found_next;
        end
    end

endmodule

FILE: design/sks_datapath.sv
module sks_datapath #(
    parameter int TABLE_DEPTH = sks_pkg::DEF_TABLE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sks_pkg::sks_in_t            in_data,
    input  logic [sks_pkg::CNT_W-1:0]   entry_count,
    input  logic [sks_pkg::SPAN_W-1:0]  linear_span,
    input  sks_pkg::sks_cmd_t           cmd,
    output sks_pkg::sks_stat_t          stat,
    input  logic                        out_stall,
    output logic                        out_valid,
    output sks_pkg::sks_out_t           out_data
);
    import sks_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DW = 17;
    localparam logic [DW-1:0] DEPTH_L = DW'(TABLE_DEPTH);

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];

    logic signed [POS_W-1:0] lo_reg, hi_reg, mid_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]        cmp_reg;
    logic                    out_valid_reg;
    sks_out_t                out_data_reg;

    logic [CNT_W-1:0]        n_count;
    logic signed [POS_W-1:0] span;
    logic signed [POS_W-1:0] mid_pos;
    logic signed [POS_W-1:0] probe_pos;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic                    wr_ok;
    logic                    key_less;

    // table holds at most TABLE_DEPTH entries
    assign n_count = (DW'(entry_count) > DEPTH_L) ? DEPTH_L[CNT_W-1:0] : entry_count;

    assign span      = hi_reg - lo_reg;
    assign mid_pos   = lo_reg + (span >>> 1);
    assign probe_pos = cmd.probe_mid ? mid_pos : lo_reg;
    assign rd_addr   = AW'($unsigned(probe_pos));
    assign wr_addr   = AW'(in_data.entry_index);
    assign wr_ok     = (DW'(in_data.entry_index) < DEPTH_L);
    assign key_less  = (rd_data_reg < key_reg);

    assign stat.span_empty = (lo_reg > hi_reg);
    assign stat.span_small = ($unsigned(span) < {2'b00, linear_span});
    assign stat.key_eq     = (rd_data_reg == key_reg);
    assign stat.out_busy   = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && wr_ok)
        begin
            key_mem[wr_addr] <= in_data.key_value;
        end
        if (cmd.probe_mid || cmd.probe_lo)
        begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= in_data.key_value;
            lo_reg  <= '0;
            hi_reg  <= $signed({1'b0, n_count}) - POS_W'(1);
            cmp_reg <= '0;
        end
        else
        begin
            if (cmd.probe_mid || cmd.probe_lo)
            begin
                mid_reg <= probe_pos;
                if (cmp_reg != '1)
                begin
                    cmp_reg <= cmp_reg + CNT_W'(1);
                end
            end
            if (cmd.step_bin)
            begin
                if (key_less)
                begin
                    lo_reg <= mid_reg + POS_W'(1);
                end
                else
                begin
                    hi_reg <= mid_reg - POS_W'(1);
                end
            end
            if (cmd.step_lin)
            begin
                lo_reg <= lo_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_data_reg.found         <= cmd.found;
            out_data_reg.found_index   <= cmd.found ? mid_reg[IDX_W-1:0] : '0;
            out_data_reg.compare_count <= cmp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: design/sorted_table_key_search.sv
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    sks_in_t  (kind, entry_index, key_value)
// out      out  out_valid / out_stall  sks_out_t (found, found_index, compare_count)
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load is written to the key table on accept and leaves in_stall low. A search
// alternates check and compare states, one registered read of the key memory per
// compare; a miss ends in a check state; hybrid drops from binary to linear checks.
// in_stall is high from a search's accept until its result is loaded into the output
// register, which may hold the previous result meanwhile; one request in flight.
// Reset clears control, out_valid and config (to defaults); key table and datapath are not cleared.
module sorted_table_key_search #(
    parameter int TABLE_DEPTH = sks_pkg::DEF_TABLE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  sks_pkg::sks_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output sks_pkg::sks_out_t               out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sks_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sks_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sks_pkg::*;

    logic [CNT_W-1:0]  entry_count_reg;
    logic [MODE_W-1:0] search_mode_reg;
    logic [SPAN_W-1:0] linear_span_reg;

    sks_cmd_t  cmd;
    sks_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            search_mode_reg <= MODE_HYBRID;
            linear_span_reg <= DEF_LINEAR_SPAN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[CNT_W-1:0];
                CFG_SEARCH_MODE: search_mode_reg <= cfg_data[MODE_W-1:0];
                CFG_LINEAR_SPAN: linear_span_reg <= cfg_data[SPAN_W-1:0];
                default:
                begin
                    entry_count_reg <= entry_count_reg;
                end
            endcase
        end
    end

    sks_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_kind     (in_data.kind),
        .search_mode (search_mode_reg),
        .stat        (stat),
        .cmd         (cmd),
        .in_stall    (in_stall)
    );

    sks_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .entry_count (entry_count_reg),
        .linear_span (linear_span_reg),
        .cmd         (cmd),
        .stat        (stat),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

endmodule
